// ----- design/pds_pkg.sv -----
// ----------------------------------------------------------------------------
// pds_pkg
// Types and constants shared by the debounced page selector: register
// indexes, cause codes, display modes and the per-sample result record.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam int unsigned TimeW      = 32;
    localparam int unsigned DebW       = 16;
    localparam int unsigned ModeW      = 2;
    localparam int unsigned CauseW     = 3;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned CfgDataW   = 32;
    localparam int unsigned NumButtons = 3;
    localparam int unsigned NumSlots   = 4;

    // Button lanes, which are also the result slots of the button events.
    localparam int unsigned BTN_PREV   = 0;
    localparam int unsigned BTN_SELECT = 1;
    localparam int unsigned BTN_NEXT   = 2;
    localparam int unsigned SLOT_MODE  = 3;

    localparam logic [ModeW-1:0] MODE_SLIDESHOW = 2'd0;
    localparam logic [ModeW-1:0] MODE_FIXED     = 2'd1;
    localparam logic [ModeW-1:0] MODE_SMART     = 2'd2;

    localparam logic [CauseW-1:0] CAUSE_PREV      = 3'd0;
    localparam logic [CauseW-1:0] CAUSE_SELECT    = 3'd1;
    localparam logic [CauseW-1:0] CAUSE_NEXT      = 3'd2;
    localparam logic [CauseW-1:0] CAUSE_SLIDE     = 3'd3;
    localparam logic [CauseW-1:0] CAUSE_ALERT_ON  = 3'd4;
    localparam logic [CauseW-1:0] CAUSE_ALERT_OFF = 3'd5;

    localparam logic [CfgIdxW-1:0] CFG_DISPLAY_MODE   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TIME  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SLIDESHOW_TIME = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ALERT_TIME     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ALERT_PAGE     = 3'd4;

    localparam logic [ModeW-1:0] RST_DISPLAY_MODE   = MODE_SLIDESHOW;
    localparam logic [DebW-1:0]  RST_DEBOUNCE_TIME  = 16'd50;
    localparam logic [TimeW-1:0] RST_SLIDESHOW_TIME = 32'd60000;
    localparam logic [TimeW-1:0] RST_ALERT_TIME     = 32'd15000;
    localparam logic             RST_ALERT_PAGE     = 1'b1;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [TimeW-1:0] slideshow_time;
        logic [TimeW-1:0] alert_time;
        logic             alert_page;
    } t_mode_cfg;

    // All results of one sample: one slot per button and one for the mode logic.
    typedef struct packed {
        logic [NumSlots-1:0]             vld;
        logic [NumSlots-1:0]             pg;
        logic [NumSlots-1:0][CauseW-1:0] cause;
    } t_run;

endpackage

// ----- design/pds_in_if.sv -----
// ----------------------------------------------------------------------------
// pds_in_if
// Sample channel: timestamp, raw button levels and alert flag.
// ----------------------------------------------------------------------------
interface pds_in_if;
    logic                                        valid;
    logic                                        ready;
    logic [pds_pkg::TimeW-1:0]                   now_ms;
    logic [pds_pkg::NumButtons-1:0]              button_levels;
    logic                                        alert_flag;

    modport source (output valid, now_ms, button_levels, alert_flag, input ready);
    modport sink   (input valid, now_ms, button_levels, alert_flag, output ready);
endinterface

// ----- design/pds_out_if.sv -----
// ----------------------------------------------------------------------------
// pds_out_if
// Result channel: page after the event, its cause and the end-of-run marker.
// ----------------------------------------------------------------------------
interface pds_out_if;
    logic                        valid;
    logic                        ready;
    logic                        page;
    logic [pds_pkg::CauseW-1:0]  cause;
    logic                        last_of_run;

    modport source (output valid, page, cause, last_of_run, input ready);
    modport sink   (input valid, page, cause, last_of_run, output ready);
endinterface

// ----- design/pds_lane.sv -----
// ----------------------------------------------------------------------------
// pds_lane
// Debouncer for one button: tracks the raw level and when it last changed,
// and flags an accepted press in the cycle the sample is taken.
// ----------------------------------------------------------------------------
module pds_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [pds_pkg::TimeW-1:0]     i_now,
    input  logic                          i_level,
    input  logic [pds_pkg::DebW-1:0]      i_debounce,
    output logic                          o_press
);

    logic                          r_last;
    logic                          r_stable;
    logic [pds_pkg::TimeW-1:0]     r_change_time;
    logic                          changed;
    logic                          settled;
    logic [pds_pkg::TimeW-1:0]     elapsed;

    assign changed = (i_level != r_last);
    assign elapsed = i_now - r_change_time;

    // A fresh change has zero elapsed time, so it only settles at once with
    // a zero debounce time.
    assign settled = changed ? (i_debounce == '0)
                             : (elapsed >= pds_pkg::TimeW'(i_debounce));
    assign o_press = settled && i_level && !r_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last        <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
        end else if (i_en) begin
            r_last <= i_level;
            if (changed) begin
                r_change_time <= i_now;
            end
            if (settled) begin
                r_stable <= i_level;
            end
        end
    end

endmodule

// ----- design/pds_merge.sv -----
// ----------------------------------------------------------------------------
// pds_merge
// Combines the lane presses in button order, runs the slideshow or alert
// logic and builds the record of all results of one sample.
// ----------------------------------------------------------------------------
module pds_merge #(
    parameter int unsigned PAGE_COUNT = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [pds_pkg::TimeW-1:0]         i_now,
    input  logic [pds_pkg::NumButtons-1:0]    i_press,
    input  logic                              i_alert,
    input  pds_pkg::t_mode_cfg                i_cfg,
    output pds_pkg::t_run                     o_run
);

    localparam int unsigned PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    logic [PW-1:0]                 r_page;
    logic [PW-1:0]                 r_saved;
    logic [pds_pkg::TimeW-1:0]     r_pct;
    logic [pds_pkg::TimeW-1:0]     r_ast;
    logic                          r_active;
    logic                          r_shown;

    logic [PW-1:0]                 n_page;
    logic [PW-1:0]                 n_saved;
    logic [pds_pkg::TimeW-1:0]     n_pct;
    logic [pds_pkg::TimeW-1:0]     n_ast;
    logic                          n_active;
    logic                          n_shown;

    logic [PW-1:0]                 p1;
    logic [PW-1:0]                 p2;
    logic [PW-1:0]                 target;
    logic                          btn_move;
    logic                          slide_due;
    logic                          alert_due;

    function automatic logic [PW-1:0] f_up(input logic [PW-1:0] p);
        f_up = (p == PW'(PAGE_COUNT - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] f_down(input logic [PW-1:0] p);
        f_down = (p == '0) ? PW'(PAGE_COUNT - 1) : p - 1'b1;
    endfunction

    assign p1       = i_press[pds_pkg::BTN_PREV] ? f_down(r_page) : r_page;
    assign p2       = i_press[pds_pkg::BTN_NEXT] ? f_up(p1) : p1;
    assign btn_move = i_press[pds_pkg::BTN_PREV] || i_press[pds_pkg::BTN_NEXT];
    assign target   = (PAGE_COUNT > 1) ? PW'(i_cfg.alert_page) : '0;

    // A button move restamps the page change time to now, leaving zero
    // elapsed time for the slideshow check.
    assign slide_due = btn_move ? (i_cfg.slideshow_time == '0)
                                : ((i_now - r_pct) >= i_cfg.slideshow_time);
    assign alert_due = (i_now - r_ast) >= i_cfg.alert_time;

    always_comb begin
        n_page   = p2;
        n_saved  = r_saved;
        n_pct    = btn_move ? i_now : r_pct;
        n_ast    = r_ast;
        n_active = r_active;
        n_shown  = r_shown;

        o_run.vld = '0;
        o_run.vld[pds_pkg::BTN_PREV]   = i_press[pds_pkg::BTN_PREV];
        o_run.vld[pds_pkg::BTN_SELECT] = i_press[pds_pkg::BTN_SELECT];
        o_run.vld[pds_pkg::BTN_NEXT]   = i_press[pds_pkg::BTN_NEXT];
        o_run.cause[pds_pkg::BTN_PREV]   = pds_pkg::CAUSE_PREV;
        o_run.cause[pds_pkg::BTN_SELECT] = pds_pkg::CAUSE_SELECT;
        o_run.cause[pds_pkg::BTN_NEXT]   = pds_pkg::CAUSE_NEXT;
        o_run.cause[pds_pkg::SLOT_MODE]  = pds_pkg::CAUSE_SLIDE;

        unique case (i_cfg.mode)
            pds_pkg::MODE_SLIDESHOW: begin
                if (slide_due) begin
                    n_page = f_up(p2);
                    n_pct  = i_now;
                    o_run.vld[pds_pkg::SLOT_MODE] = 1'b1;
                end
            end
            pds_pkg::MODE_SMART: begin
                if (!i_alert) begin
                    n_shown = 1'b0;
                end
                if (r_active) begin
                    if (alert_due) begin
                        n_page   = r_saved;
                        n_pct    = i_now;
                        n_active = 1'b0;
                        o_run.vld[pds_pkg::SLOT_MODE]   = 1'b1;
                        o_run.cause[pds_pkg::SLOT_MODE] = pds_pkg::CAUSE_ALERT_OFF;
                    end
                end else if (i_alert && !r_shown && (p2 != target)) begin
                    n_saved  = p2;
                    n_page   = target;
                    n_ast    = i_now;
                    n_active = 1'b1;
                    n_shown  = 1'b1;
                    o_run.vld[pds_pkg::SLOT_MODE]   = 1'b1;
                    o_run.cause[pds_pkg::SLOT_MODE] = pds_pkg::CAUSE_ALERT_ON;
                end
            end
            default: begin
                // Fixed mode and the unused code: no automatic change.
            end
        endcase

        o_run.pg[pds_pkg::BTN_PREV]   = p1[0];
        o_run.pg[pds_pkg::BTN_SELECT] = p1[0];
        o_run.pg[pds_pkg::BTN_NEXT]   = p2[0];
        o_run.pg[pds_pkg::SLOT_MODE]  = n_page[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page   <= '0;
            r_saved  <= '0;
            r_pct    <= '0;
            r_ast    <= '0;
            r_active <= 1'b0;
            r_shown  <= 1'b0;
        end else if (i_en) begin
            r_page   <= n_page;
            r_saved  <= n_saved;
            r_pct    <= n_pct;
            r_ast    <= n_ast;
            r_active <= n_active;
            r_shown  <= n_shown;
        end
    end

`ifndef SYNTHESIS
    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_page) < PAGE_COUNT) && (32'(r_saved) < PAGE_COUNT))
        else $error("active or saved page out of range");
`endif

endmodule

// ----- design/pds_outq.sv -----
// ----------------------------------------------------------------------------
// pds_outq
// Two-record queue of per-sample results, unrolled one beat per cycle while
// i_take is high, with the end-of-run marker on the last beat of each record.
// ----------------------------------------------------------------------------
module pds_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  pds_pkg::t_run                 i_run,
    output logic                          o_ready,
    output logic                          o_valid,
    input  logic                          i_take,
    output logic                          o_page,
    output logic [pds_pkg::CauseW-1:0]    o_cause,
    output logic                          o_last
);

    pds_pkg::t_run                  r_rec [2];
    logic                           r_wp;
    logic                           r_rp;
    logic [1:0]                     r_cnt;
    logic [1:0]                     n_cnt;

    pds_pkg::t_run                  head;
    logic [pds_pkg::NumSlots-1:0]   sel;
    logic [pds_pkg::NumSlots-1:0]   rest;
    logic                           beat;
    logic                           pop;

    assign head    = r_rec[r_rp];
    assign sel     = head.vld & (~head.vld + 1'b1);
    assign rest    = head.vld & ~sel;
    assign o_valid = (r_cnt != 2'd0);
    assign o_ready = (r_cnt != 2'd2);
    assign o_last  = (rest == '0);
    assign beat    = o_valid && i_take;
    assign pop     = beat && o_last;
    assign n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, pop};

    always_comb begin
        o_page  = 1'b0;
        o_cause = '0;
        for (int s = 0; s < pds_pkg::NumSlots; s++) begin
            o_page  = o_page  | (sel[s] & head.pg[s]);
            o_cause = o_cause | ({pds_pkg::CauseW{sel[s]}} & head.cause[s]);
        end
    end

    // Payload: a push only lands on the free record, never on the head.
    always_ff @(posedge i_clk) begin
        if (beat && !o_last) begin
            r_rec[r_rp].vld <= rest;
        end
        if (i_push) begin
            r_rec[r_wp] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue overfilled");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (head.vld != '0))
        else $error("queued record holds no result");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push && (r_cnt == 2'd1)) |=> !o_valid)
        else $error("queue not empty after final beat");
`endif

endmodule

// ----- design/debounced_page_selector.sv -----
// ----------------------------------------------------------------------------
// debounced_page_selector
// Three debounced buttons and a slideshow/alert timer select the active page;
// every page change or redraw request is reported as one result beat.
// ----------------------------------------------------------------------------
// Output: the results of an accepted sample are registered into the result
// queue and offered from there, behind any record still queued ahead of them.
// Throughput: one sample per cycle unless the two-record result queue is full,
// which sets how far input runs ahead; a sample with n results gives n beats.
// Reset: synchronous, active low; buttons released, page 0, registers at
// their documented defaults, result queue empty.
// ----------------------------------------------------------------------------
module debounced_page_selector #(
    parameter int unsigned PAGE_COUNT = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pds_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [pds_pkg::CfgDataW-1:0]       i_cfg_data,
    pds_in_if.sink                             i_in,
    pds_out_if.source                          o_out
);

    logic [pds_pkg::ModeW-1:0]         r_display_mode;
    logic [pds_pkg::DebW-1:0]          r_debounce_time;
    logic [pds_pkg::TimeW-1:0]         r_slideshow_time;
    logic [pds_pkg::TimeW-1:0]         r_alert_time;
    logic                              r_alert_page;

    logic                              accept;
    logic [pds_pkg::NumButtons-1:0]    press;
    pds_pkg::t_mode_cfg                mode_cfg;
    pds_pkg::t_run                     run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode   <= pds_pkg::RST_DISPLAY_MODE;
            r_debounce_time  <= pds_pkg::RST_DEBOUNCE_TIME;
            r_slideshow_time <= pds_pkg::RST_SLIDESHOW_TIME;
            r_alert_time     <= pds_pkg::RST_ALERT_TIME;
            r_alert_page     <= pds_pkg::RST_ALERT_PAGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pds_pkg::CFG_DISPLAY_MODE:
                    r_display_mode <= i_cfg_data[pds_pkg::ModeW-1:0];
                pds_pkg::CFG_DEBOUNCE_TIME:
                    r_debounce_time <= i_cfg_data[pds_pkg::DebW-1:0];
                pds_pkg::CFG_SLIDESHOW_TIME:
                    r_slideshow_time <= i_cfg_data[pds_pkg::TimeW-1:0];
                pds_pkg::CFG_ALERT_TIME:
                    r_alert_time <= i_cfg_data[pds_pkg::TimeW-1:0];
                pds_pkg::CFG_ALERT_PAGE:
                    r_alert_page <= i_cfg_data[0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign accept = i_in.valid && i_in.ready;

    for (genvar b = 0; b < pds_pkg::NumButtons; b++) begin : g_lane
        pds_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (accept),
            .i_now      (i_in.now_ms),
            .i_level    (i_in.button_levels[b]),
            .i_debounce (r_debounce_time),
            .o_press    (press[b])
        );
    end

    assign mode_cfg.mode           = r_display_mode;
    assign mode_cfg.slideshow_time = r_slideshow_time;
    assign mode_cfg.alert_time     = r_alert_time;
    assign mode_cfg.alert_page     = r_alert_page;

    pds_merge #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_now   (i_in.now_ms),
        .i_press (press),
        .i_alert (i_in.alert_flag),
        .i_cfg   (mode_cfg),
        .o_run   (run)
    );

    // Samples without results pass straight through and queue nothing.
    pds_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && (run.vld != '0)),
        .i_run   (run),
        .o_ready (i_in.ready),
        .o_valid (o_out.valid),
        .i_take  (o_out.ready),
        .o_page  (o_out.page),
        .o_cause (o_out.cause),
        .o_last  (o_out.last_of_run)
    );

endmodule

// ----- sim/tb_debounced_page_selector.sv -----
// ----------------------------------------------------------------------------
// tb_debounced_page_selector
// Drives timestamped button and alert samples into the page selector, keeps
// its own copy of the debouncers, page counter and alert logic, and checks
// every result beat in order against that copy while both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_debounced_page_selector;
    timeunit 1ns;
    timeprecision 1ps;

    import pds_pkg::*;

    localparam int unsigned PAGES        = 2;
    localparam int unsigned QUIET_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS  = 26;

    // The spare mode encoding, which the block treats like fixed.
    localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic              page;
        logic [CauseW-1:0] cause;
        logic              last;
    } t_page_event;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CfgIdxW-1:0]   i_cfg_idx;
    logic [CfgDataW-1:0]  i_cfg_data;

    pds_in_if  smp_if ();
    pds_out_if res_if ();

    debounced_page_selector #(
        .PAGE_COUNT (PAGES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (smp_if),
        .o_out      (res_if)
    );

    always #5ns i_clk = ~i_clk;

    // Shadow copy of the registers and of the selector state.
    logic [ModeW-1:0]      m_mode;
    logic [DebW-1:0]       m_debounce;
    logic [TimeW-1:0]      m_slide_ms;
    logic [TimeW-1:0]      m_alert_ms;
    logic                  m_alert_page;
    logic [NumButtons-1:0] btn_stable;
    logic [NumButtons-1:0] btn_raw;
    logic [TimeW-1:0]      btn_since [NumButtons];
    int unsigned           cur_page;
    logic [TimeW-1:0]      page_stamp;
    logic [TimeW-1:0]      alert_stamp;
    logic                  alert_up;
    logic                  alert_seen;
    int unsigned           page_before_alert;

    t_page_event pending_events [$];
    int          err_count = 0;
    int unsigned cycle_count = 0;
    bit          smp_idle;
    bit          res_idle;
    bit          hold_req;
    logic [TimeW-1:0] sample_clock_ms;
    logic             alert_line;

    function automatic void model_reset();
        m_mode       = RST_DISPLAY_MODE;
        m_debounce   = RST_DEBOUNCE_TIME;
        m_slide_ms   = RST_SLIDESHOW_TIME;
        m_alert_ms   = RST_ALERT_TIME;
        m_alert_page = RST_ALERT_PAGE;
        btn_stable   = '0;
        btn_raw      = '0;
        foreach (btn_since[b]) btn_since[b] = '0;
        cur_page          = 0;
        page_stamp        = '0;
        alert_stamp       = '0;
        alert_up          = 1'b0;
        alert_seen        = 1'b0;
        page_before_alert = 0;
    endfunction

    function automatic void note_event(input logic [CauseW-1:0] cause);
        pending_events.push_back('{page: cur_page[0], cause: cause, last: 1'b0});
    endfunction

    // Works out the result beats of one accepted sample and queues them.
    function automatic void apply_sample(input logic [TimeW-1:0] now,
                                         input logic [NumButtons-1:0] lv,
                                         input logic alert);
        int unsigned      queued_at_entry;
        int unsigned      target;
        logic [TimeW-1:0] elapsed;
        logic             rd;
        t_page_event      tail;
        queued_at_entry = pending_events.size();
        for (int b = 0; b < NumButtons; b++) begin
            rd = lv[b];
            if (rd != btn_raw[b]) begin
                btn_raw[b]   = rd;
                btn_since[b] = now;
            end
            elapsed = now - btn_since[b];
            if (elapsed >= TimeW'(m_debounce) && rd != btn_stable[b]) begin
                btn_stable[b] = rd;
                if (rd) begin
                    if (b == BTN_PREV) begin
                        cur_page   = (cur_page + PAGES - 1) % PAGES;
                        page_stamp = now;
                        note_event(CAUSE_PREV);
                    end else if (b == BTN_NEXT) begin
                        cur_page   = (cur_page + 1) % PAGES;
                        page_stamp = now;
                        note_event(CAUSE_NEXT);
                    end else begin
                        note_event(CAUSE_SELECT);
                    end
                end
            end
        end

        case (m_mode)
            MODE_SLIDESHOW: begin
                elapsed = now - page_stamp;
                if (elapsed >= m_slide_ms) begin
                    cur_page   = (cur_page + 1) % PAGES;
                    page_stamp = now;
                    note_event(CAUSE_SLIDE);
                end
            end
            MODE_SMART: begin
                target = int'(m_alert_page) % PAGES;
                if (!alert) alert_seen = 1'b0;
                if (alert_up) begin
                    elapsed = now - alert_stamp;
                    // The saved page comes back even if the buttons moved it meanwhile.
                    if (elapsed >= m_alert_ms) begin
                        cur_page   = page_before_alert;
                        page_stamp = now;
                        alert_up   = 1'b0;
                        note_event(CAUSE_ALERT_OFF);
                    end
                end else if (alert && !alert_seen && cur_page != target) begin
                    page_before_alert = cur_page;
                    cur_page          = target;
                    alert_stamp       = now;
                    alert_up          = 1'b1;
                    alert_seen        = 1'b1;
                    note_event(CAUSE_ALERT_ON);
                end
            end
            default: begin
            end
        endcase

        if (pending_events.size() > queued_at_entry) begin
            tail      = pending_events.pop_back();
            tail.last = 1'b1;
            pending_events.push_back(tail);
        end
    endfunction

    // Stops offering samples and waits until every expected beat has arrived.
    task automatic wait_idle();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_DISPLAY_MODE:   m_mode       = data[ModeW-1:0];
            CFG_DEBOUNCE_TIME:  m_debounce   = data[DebW-1:0];
            CFG_SLIDESHOW_TIME: m_slide_ms   = data;
            CFG_ALERT_TIME:     m_alert_ms   = data;
            CFG_ALERT_PAGE:     m_alert_page = data[0];
            default: begin
            end
        endcase
    endtask

    task automatic send_sample(input logic [TimeW-1:0] now,
                               input logic [NumButtons-1:0] lv,
                               input logic alert);
        int unsigned gap;
        gap = smp_idle ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid         <= 1'b1;
        smp_if.now_ms        <= now;
        smp_if.button_levels <= lv;
        smp_if.alert_flag    <= alert;
        do @(posedge i_clk); while (!smp_if.ready);
        apply_sample(now, lv, alert);
    endtask

    function automatic logic [TimeW-1:0] pick_span();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2, 3:    return TimeW'($urandom_range(1, 300));
            4:       return TimeW'($urandom_range(301, 5000));
            5:       return TimeW'($urandom);
            default: return TimeW'($urandom_range(1, 150));
        endcase
    endfunction

    task automatic test_reset_defaults();
        // Registers at their reset values: slideshow, 50 ms debounce, 60 s interval.
        send_sample(32'd0,     3'b001, 1'b0);
        send_sample(32'd50,    3'b001, 1'b0);
        send_sample(32'd60050, 3'b001, 1'b0);
    endtask

    task automatic test_button_extremes();
        write_reg(CFG_DISPLAY_MODE, CfgDataW'(MODE_FIXED));
        write_reg(CFG_DEBOUNCE_TIME, '0);
        send_sample(32'd90,  3'b000, 1'b0);
        // All three presses land in one sample: previous, select, next.
        send_sample(32'd100, 3'b111, 1'b1);
        send_sample(32'd101, 3'b000, 1'b0);
        write_reg(CFG_DEBOUNCE_TIME, CfgDataW'({DebW{1'b1}}));
        send_sample(32'd200,   3'b101, 1'b0);
        send_sample(32'd65734, 3'b101, 1'b0);
        send_sample(32'd65735, 3'b101, 1'b0);
    endtask

    task automatic test_slideshow();
        write_reg(CFG_DISPLAY_MODE, CfgDataW'(MODE_SLIDESHOW));
        write_reg(CFG_DEBOUNCE_TIME, CfgDataW'(1));
        write_reg(CFG_SLIDESHOW_TIME, '0);
        send_sample(32'd80000, 3'b000, 1'b0);
        send_sample(32'd80005, 3'b000, 1'b0);
        send_sample(32'd80010, 3'b111, 1'b0);
        // Three presses plus the automatic advance: the fullest sample there is.
        send_sample(32'd80011, 3'b111, 1'b0);
        write_reg(CFG_SLIDESHOW_TIME, '1);
        // Going back one millisecond makes the elapsed time wrap to its maximum.
        send_sample(32'd80010, 3'b111, 1'b0);
    endtask

    task automatic test_timestamp_wrap();
        write_reg(CFG_DISPLAY_MODE, CfgDataW'(MODE_UNUSED));
        write_reg(CFG_DEBOUNCE_TIME, CfgDataW'(50));
        write_reg(CFG_SLIDESHOW_TIME, '0);
        send_sample(32'hFFFF_FF00, 3'b000, 1'b0);
        send_sample(32'hFFFF_FFF0, 3'b000, 1'b0);
        send_sample(32'hFFFF_FFF8, 3'b100, 1'b0);
        send_sample(32'h0000_002A, 3'b100, 1'b0);
    endtask

    task automatic test_smart_alert();
        write_reg(CFG_DISPLAY_MODE, CfgDataW'(MODE_SMART));
        write_reg(CFG_DEBOUNCE_TIME, '0);
        write_reg(CFG_ALERT_TIME, CfgDataW'(100));
        write_reg(CFG_ALERT_PAGE, CfgDataW'((cur_page + 1) % PAGES));
        send_sample(32'd1000, 3'b000, 1'b1);
        send_sample(32'd1010, 3'b100, 1'b1);
        send_sample(32'd1100, 3'b000, 1'b1);
        // Flag still high after the episode: no second alert until it drops.
        send_sample(32'd1110, 3'b000, 1'b1);
        send_sample(32'd1120, 3'b000, 1'b0);
        send_sample(32'd1130, 3'b000, 1'b1);
        write_reg(CFG_ALERT_TIME, '0);
        send_sample(32'd1131, 3'b000, 1'b1);
        // Alert page equal to the current one: nothing starts.
        write_reg(CFG_ALERT_PAGE, CfgDataW'(cur_page));
        send_sample(32'd1140, 3'b000, 1'b0);
        send_sample(32'd1150, 3'b000, 1'b1);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_DISPLAY_MODE, CfgDataW'(MODE_FIXED));
        write_reg(CFG_DEBOUNCE_TIME, '0);
        sample_clock_ms = 32'd5000;
        smp_idle = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            sample_clock_ms += 5;
            send_sample(sample_clock_ms, i[0] ? 3'b000 : 3'b111, 1'b0);
        end
        smp_idle = 1'b1;
    endtask

    // Mostly press-and-hold runs with random timing, some glitches and some
    // samples that are random in every field.
    task automatic drive_burst(input int count);
        int                    sent;
        int                    reps;
        logic [NumButtons-1:0] mask;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                sample_clock_ms = $urandom;
                send_sample(sample_clock_ms, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                mask = 3'($urandom_range(0, 7));
                reps = $urandom_range(1, 4);
                repeat (reps) begin
                    if ($urandom_range(0, 5) == 0) alert_line = ~alert_line;
                    if ($urandom_range(0, 15) == 0)
                        sample_clock_ms += $urandom_range(0, 200000);
                    else
                        sample_clock_ms += $urandom_range(0, int'(m_debounce) / 2 + 3);
                    if ($urandom_range(0, 11) == 0) begin
                        send_sample(sample_clock_ms, mask ^ 3'($urandom_range(1, 7)), alert_line);
                        sent++;
                    end
                    send_sample(sample_clock_ms, mask, alert_line);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_phases();
        logic [ModeW-1:0] mode_order [4];
        logic [DebW-1:0]  deb;
        mode_order = '{MODE_SLIDESHOW, MODE_FIXED, MODE_SMART, MODE_UNUSED};
        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       deb = '0;
                1:       deb = '1;
                2, 3:    deb = DebW'($urandom_range(1, 40));
                4:       deb = DebW'($urandom_range(41, 3000));
                default: deb = DebW'($urandom_range(0, 65535));
            endcase
            write_reg(CFG_DISPLAY_MODE,
                      CfgDataW'(p < 4 ? mode_order[p] : mode_order[$urandom_range(0, 3)]));
            write_reg(CFG_DEBOUNCE_TIME, CfgDataW'(deb));
            write_reg(CFG_SLIDESHOW_TIME, pick_span());
            write_reg(CFG_ALERT_TIME, pick_span());
            write_reg(CFG_ALERT_PAGE, CfgDataW'($urandom_range(0, 1)));
            smp_idle = ($urandom_range(0, 2) != 0);
            res_idle = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) == 0)
                sample_clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            drive_burst(PHASE_ITEMS);
        end
    endtask

    // Result side: random stalls per beat, plus one long hold-off on request.
    initial begin : result_sink
        int unsigned gap;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = res_idle ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid && !hold_req);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_page_event want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: result beat with none expected: page %0d cause %0d last %0d",
                         $time, res_if.page, res_if.cause, res_if.last_of_run);
                err_count++;
            end else begin
                want = pending_events.pop_front();
                if (res_if.page !== want.page) begin
                    $display("%0t: page expected %0d actual %0d", $time, want.page, res_if.page);
                    err_count++;
                end
                if (res_if.cause !== want.cause) begin
                    $display("%0t: cause expected %0d actual %0d",
                             $time, want.cause, res_if.cause);
                    err_count++;
                end
                if (res_if.last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0d actual %0d",
                             $time, want.last, res_if.last_of_run);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d beats outstanding", $time, pending_events.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= '0;
        i_cfg_data           <= '0;
        smp_if.valid         <= 1'b0;
        smp_if.now_ms        <= '0;
        smp_if.button_levels <= '0;
        smp_if.alert_flag    <= 1'b0;
        smp_idle        = 1'b1;
        res_idle        = 1'b1;
        hold_req        = 1'b0;
        sample_clock_ms = '0;
        alert_line      = 1'b0;
        model_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_button_extremes();
        test_slideshow();
        test_timestamp_wrap();
        test_smart_alert();
        test_backpressure();
        test_random_phases();

        wait_idle();
        if (pending_events.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, pending_events.size());
            err_count++;
        end
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
